FILE: hw/rtl/tsd_pkg.sv
// ----------------------------------------------------------------------------
// Targa stream decoder package
// Shared constants, codes and types of the Targa stream decoder.
// ----------------------------------------------------------------------------
package tsd_pkg;

    // Colour table size and its address width.
    localparam int COLOR_TABLE_DEPTH = 256;
    localparam int CT_AW             = $clog2(COLOR_TABLE_DEPTH);

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

    // Header layout.
    localparam logic [15:0] HDR_ID_LEN     = 16'd0;
    localparam logic [15:0] HDR_FILE_TYPE  = 16'd2;
    localparam logic [15:0] HDR_CMAP_LEN_L = 16'd5;
    localparam logic [15:0] HDR_CMAP_LEN_H = 16'd6;
    localparam logic [15:0] HDR_CMAP_BITS  = 16'd7;
    localparam logic [15:0] HDR_WIDTH_L    = 16'd12;
    localparam logic [15:0] HDR_WIDTH_H    = 16'd13;
    localparam logic [15:0] HDR_HEIGHT_L   = 16'd14;
    localparam logic [15:0] HDR_HEIGHT_H   = 16'd15;
    localparam logic [15:0] HDR_PIX_BITS   = 16'd16;
    localparam logic [15:0] HDR_DESCRIPTOR = 16'd17;
    localparam logic [16:0] HDR_LEN        = 17'd18;

    // File types.
    localparam logic [7:0] FT_CMAP     = 8'd1;
    localparam logic [7:0] FT_TRUE     = 8'd2;
    localparam logic [7:0] FT_GREY     = 8'd3;
    localparam logic [7:0] FT_RLE_CMAP = 8'd9;
    localparam logic [7:0] FT_RLE_TRUE = 8'd10;

    // Status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_BAD_CMAP    = 2'd2;
    localparam logic [1:0] ST_TRUNCATED   = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_CMAP,
        PH_PACKET,
        PH_PIXEL,
        PH_STOP
    } t_phase;

    // Image geometry, stable while pixels are decoded.
    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic        top_down;
    } t_geom;

    // One classified item for the back.
    typedef struct packed {
        logic [1:0]  status;
        logic        has;
        logic        done;
        logic [23:0] rgb;
        logic [7:0]  len;
    } t_cmd;

endpackage

FILE: hw/rtl/tsd_if.sv
// ----------------------------------------------------------------------------
// Targa stream decoder channels
// Valid/ready channels for file bytes in and decoded runs out.
// ----------------------------------------------------------------------------
interface tsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tsd_run_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        has_pixels;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  run_length;
    logic [15:0] row;
    logic [15:0] column;
    logic        image_done;

    modport source (output valid, output status, output has_pixels, output red,
                    output green, output blue, output run_length, output row,
                    output column, output image_done, input ready);
    modport sink (input valid, input status, input has_pixels, input red,
                  input green, input blue, input run_length, input row,
                  input column, input image_done, output ready);
endinterface

FILE: hw/rtl/tsd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/tsd_front.sv
// ----------------------------------------------------------------------------
// Targa stream decoder front
// Parses the header, ID field and colour map, assembles pixels and packets,
// clips runs to the image and hands classified items to the queue.
// ----------------------------------------------------------------------------
module tsd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    tsd_byte_if.sink               i_byte,
    input  logic [tsd_pkg::Q_CW-1:0] i_queue_level,
    output logic                   o_push,
    output tsd_pkg::t_cmd          o_push_data,
    output tsd_pkg::t_geom         o_geom
);

    tsd_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_byte_cnt, n_byte_cnt;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [7:0]  r_id_len, n_id_len;
    logic [7:0]  r_file_type, n_file_type;
    logic [15:0] r_cmap_len, n_cmap_len;
    logic [4:0]  r_entry_size, n_entry_size;
    logic [4:0]  r_pix_size, n_pix_size;
    logic        r_top_down, n_top_down;
    logic        r_run_coded, n_run_coded;
    logic [23:0] r_asm, n_asm;
    logic [2:0]  r_gathered, n_gathered;
    logic [6:0]  r_remaining, n_remaining;
    logic        r_repeat, n_repeat;
    logic [31:0] r_left, n_left;
    logic [31:0] r_total;

    // Second stage: waits for the registered colour table read.
    logic          r_s2_valid;
    tsd_pkg::t_cmd r_s2_cmd;
    logic          r_s2_table;
    logic          r_s2_idx_ok;

    tsd_pkg::t_cmd                 cmd;
    logic                          emit;
    logic                          use_table;
    logic                          idx_ok;
    logic                          acc;
    logic [7:0]                    d;
    logic [23:0]                   merged;
    logic [2:0]                    gath_inc;
    logic [16:0]                   cnt_inc;
    logic                          go_after_id;
    logic                          go_enter;
    logic [7:0]                    run_n;
    logic [7:0]                    clip_n;
    logic [31:0]                   left_after;
    logic                          ct_we;
    logic [tsd_pkg::CT_AW-1:0]     ct_waddr;
    logic [tsd_pkg::CT_AW-1:0]     ct_raddr;
    logic [23:0]                   ct_wdata;
    logic [23:0]                   ct_rdata;

    // Converts gathered little-endian bytes to 8-bit RGB.
    function automatic logic [23:0] to_rgb(input logic [23:0] a, input logic [4:0] size);
        logic [23:0] res;
        if (size == 5'd2) begin
            res = {a[14:10], 3'b000, a[9:8], a[7:5], 3'b000, a[4:0], 3'b000};
        end else begin
            res = {a[23:16], a[15:8], a[7:0]};
        end
        return res;
    endfunction

    // Accept while the queue has room for this item and the one in flight.
    assign i_byte.ready = ({1'b0, i_queue_level} + {{tsd_pkg::Q_CW{1'b0}}, r_s2_valid})
                          <= (tsd_pkg::Q_CW + 1)'(tsd_pkg::QUEUE_DEPTH - 1);
    assign acc = i_byte.valid && i_byte.ready;
    assign d   = i_byte.data_byte;

    // Byte merged into the assembly register.
    always_comb begin
        merged = r_asm;
        if (r_gathered[1:0] != 2'd3) begin
            merged[8 * r_gathered[1:0] +: 8] = d;
        end
    end
    assign gath_inc = r_gathered + 3'd1;
    assign cnt_inc  = {1'b0, r_byte_cnt} + 17'd1;

    // Parser next state.
    always_comb begin
        n_phase      = r_phase;
        n_byte_cnt   = r_byte_cnt;
        n_width      = r_width;
        n_height     = r_height;
        n_id_len     = r_id_len;
        n_file_type  = r_file_type;
        n_cmap_len   = r_cmap_len;
        n_entry_size = r_entry_size;
        n_pix_size   = r_pix_size;
        n_top_down   = r_top_down;
        n_run_coded  = r_run_coded;
        n_asm        = r_asm;
        n_gathered   = r_gathered;
        n_remaining  = r_remaining;
        n_repeat     = r_repeat;
        n_left       = r_left;
        cmd          = '0;
        emit         = 1'b0;
        use_table    = 1'b0;
        go_after_id  = 1'b0;
        go_enter     = 1'b0;
        run_n        = 8'd1;
        clip_n       = 8'd1;
        left_after   = r_left;
        ct_we        = 1'b0;
        ct_waddr     = tsd_pkg::CT_AW'(r_byte_cnt);
        ct_wdata     = to_rgb(merged, r_entry_size);
        ct_raddr     = tsd_pkg::CT_AW'(merged[7:0]);
        idx_ok       = 32'(merged[7:0]) < tsd_pkg::COLOR_TABLE_DEPTH;

        if (acc) begin
            case (r_phase)
                tsd_pkg::PH_HEADER: begin
                    case (r_byte_cnt)
                        tsd_pkg::HDR_ID_LEN:     n_id_len = d;
                        tsd_pkg::HDR_FILE_TYPE:  n_file_type = d;
                        tsd_pkg::HDR_CMAP_LEN_L: n_cmap_len[7:0] = d;
                        tsd_pkg::HDR_CMAP_LEN_H: n_cmap_len[15:8] = d;
                        tsd_pkg::HDR_CMAP_BITS:  n_entry_size = d[7:3];
                        tsd_pkg::HDR_WIDTH_L:    n_width[7:0] = d;
                        tsd_pkg::HDR_WIDTH_H:    n_width[15:8] = d;
                        tsd_pkg::HDR_HEIGHT_L:   n_height[7:0] = d;
                        tsd_pkg::HDR_HEIGHT_H:   n_height[15:8] = d;
                        tsd_pkg::HDR_PIX_BITS:   n_pix_size = d[7:3];
                        tsd_pkg::HDR_DESCRIPTOR: n_top_down = d[5];
                        default: ;
                    endcase
                    n_byte_cnt = cnt_inc[15:0];
                    if (cnt_inc == tsd_pkg::HDR_LEN) begin
                        n_byte_cnt = '0;
                        if (!(r_file_type == tsd_pkg::FT_CMAP || r_file_type == tsd_pkg::FT_TRUE
                              || r_file_type == tsd_pkg::FT_GREY
                              || r_file_type == tsd_pkg::FT_RLE_CMAP
                              || r_file_type == tsd_pkg::FT_RLE_TRUE)
                            || r_pix_size < 5'd1 || r_pix_size > 5'd4) begin
                            emit       = 1'b1;
                            cmd.status = tsd_pkg::ST_UNSUPPORTED;
                            n_phase    = tsd_pkg::PH_STOP;
                        end else begin
                            n_run_coded = (r_file_type == tsd_pkg::FT_RLE_CMAP)
                                          || (r_file_type == tsd_pkg::FT_RLE_TRUE);
                            if (r_id_len != 8'd0) begin
                                n_phase = tsd_pkg::PH_ID;
                            end else begin
                                go_after_id = 1'b1;
                            end
                        end
                    end
                end
                tsd_pkg::PH_ID: begin
                    n_byte_cnt = cnt_inc[15:0];
                    if (cnt_inc >= {9'd0, r_id_len}) begin
                        go_after_id = 1'b1;
                    end
                end
                tsd_pkg::PH_CMAP: begin
                    n_asm      = merged;
                    n_gathered = gath_inc;
                    if ({2'b00, gath_inc} >= r_entry_size) begin
                        ct_we      = 32'(r_byte_cnt) < tsd_pkg::COLOR_TABLE_DEPTH;
                        n_asm      = '0;
                        n_gathered = '0;
                        n_byte_cnt = cnt_inc[15:0];
                        if (cnt_inc >= {1'b0, r_cmap_len}) begin
                            go_enter = 1'b1;
                        end
                    end
                end
                tsd_pkg::PH_PACKET: begin
                    n_repeat    = d[7];
                    n_remaining = d[6:0];
                    n_asm       = '0;
                    n_gathered  = '0;
                    n_phase     = tsd_pkg::PH_PIXEL;
                end
                tsd_pkg::PH_PIXEL: begin
                    n_asm      = merged;
                    n_gathered = gath_inc;
                    if ({2'b00, gath_inc} >= r_pix_size) begin
                        n_asm      = '0;
                        n_gathered = '0;
                        if (r_run_coded && r_repeat) begin
                            run_n       = {1'b0, r_remaining} + 8'd1;
                            n_remaining = '0;
                            n_phase     = tsd_pkg::PH_PACKET;
                        end else if (r_run_coded) begin
                            if (r_remaining == 7'd0) begin
                                n_phase = tsd_pkg::PH_PACKET;
                            end else begin
                                n_remaining = r_remaining - 7'd1;
                            end
                        end
                        clip_n     = (32'(run_n) > r_left) ? r_left[7:0] : run_n;
                        left_after = r_left - 32'(clip_n);
                        n_left     = left_after;
                        emit       = 1'b1;
                        use_table  = (r_pix_size == 5'd1);
                        cmd.has    = 1'b1;
                        cmd.rgb    = to_rgb(merged, r_pix_size);
                        cmd.len    = clip_n;
                        if (left_after == 32'd0) begin
                            cmd.done = 1'b1;
                            n_phase  = tsd_pkg::PH_STOP;
                        end
                    end
                end
                default: ;
            endcase

            // Colour map checks once the ID field is behind.
            if (go_after_id) begin
                if (r_cmap_len == 16'd0 && r_pix_size == 5'd1) begin
                    emit       = 1'b1;
                    cmd.status = tsd_pkg::ST_BAD_CMAP;
                    n_phase    = tsd_pkg::PH_STOP;
                end else if (r_cmap_len != 16'd0 && (r_pix_size != 5'd1
                             || r_entry_size < 5'd2 || r_entry_size > 5'd4)) begin
                    emit       = 1'b1;
                    cmd.status = tsd_pkg::ST_BAD_CMAP;
                    n_phase    = tsd_pkg::PH_STOP;
                end else if (r_cmap_len != 16'd0) begin
                    n_phase    = tsd_pkg::PH_CMAP;
                    n_byte_cnt = '0;
                    n_asm      = '0;
                    n_gathered = '0;
                end else begin
                    go_enter = 1'b1;
                end
            end

            // Start of pixel data; an empty image ends here. The coding flag
            // may be set by this very byte when the header is the last field.
            if (go_enter) begin
                n_asm      = '0;
                n_gathered = '0;
                n_left     = r_total;
                if (r_width == 16'd0 || r_height == 16'd0) begin
                    emit     = 1'b1;
                    cmd.done = 1'b1;
                    n_phase  = tsd_pkg::PH_STOP;
                end else begin
                    n_phase = n_run_coded ? tsd_pkg::PH_PACKET : tsd_pkg::PH_PIXEL;
                end
            end

            // Final byte before the image ends.
            if (i_byte.last_byte && n_phase != tsd_pkg::PH_STOP) begin
                emit       = 1'b1;
                cmd.status = tsd_pkg::ST_TRUNCATED;
                n_phase    = tsd_pkg::PH_STOP;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tsd_pkg::PH_HEADER;
            r_byte_cnt   <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_id_len     <= '0;
            r_file_type  <= '0;
            r_cmap_len   <= '0;
            r_entry_size <= '0;
            r_pix_size   <= '0;
            r_top_down   <= 1'b0;
            r_run_coded  <= 1'b0;
            r_asm        <= '0;
            r_gathered   <= '0;
            r_remaining  <= '0;
            r_repeat     <= 1'b0;
            r_left       <= '0;
            r_s2_valid   <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_byte_cnt   <= n_byte_cnt;
            r_width      <= n_width;
            r_height     <= n_height;
            r_id_len     <= n_id_len;
            r_file_type  <= n_file_type;
            r_cmap_len   <= n_cmap_len;
            r_entry_size <= n_entry_size;
            r_pix_size   <= n_pix_size;
            r_top_down   <= n_top_down;
            r_run_coded  <= n_run_coded;
            r_asm        <= n_asm;
            r_gathered   <= n_gathered;
            r_remaining  <= n_remaining;
            r_repeat     <= n_repeat;
            r_left       <= n_left;
            r_s2_valid   <= emit;
        end
    end

    // Pixel count of the image and the second stage payload.
    always_ff @(posedge i_clk) begin
        r_total     <= r_width * r_height;
        r_s2_cmd    <= cmd;
        r_s2_table  <= use_table;
        r_s2_idx_ok <= idx_ok;
    end

    tsd_ram #(
        .WIDTH(24),
        .DEPTH(tsd_pkg::COLOR_TABLE_DEPTH)
    ) u_color_table (
        .i_clk  (i_clk),
        .i_we   (ct_we),
        .i_waddr(ct_waddr),
        .i_wdata(ct_wdata),
        .i_raddr(ct_raddr),
        .o_rdata(ct_rdata)
    );

    // Indexed pixels take their colour from the table.
    always_comb begin
        o_push_data = r_s2_cmd;
        if (r_s2_table) begin
            o_push_data.rgb = r_s2_idx_ok ? ct_rdata : 24'd0;
        end
    end
    assign o_push = r_s2_valid;

    assign o_geom.width    = r_width;
    assign o_geom.height   = r_height;
    assign o_geom.top_down = r_top_down;

endmodule

FILE: hw/rtl/tsd_queue.sv
// ----------------------------------------------------------------------------
// Targa stream decoder queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module tsd_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  tsd_pkg::t_cmd            i_push_data,
    input  logic                     i_pop,
    output logic                     o_head_valid,
    output tsd_pkg::t_cmd            o_head,
    output logic [tsd_pkg::Q_CW-1:0] o_level
);

    tsd_pkg::t_cmd             r_slot [tsd_pkg::QUEUE_DEPTH];
    logic [tsd_pkg::Q_AW-1:0]  r_wptr, n_wptr;
    logic [tsd_pkg::Q_AW-1:0]  r_rptr, n_rptr;
    logic [tsd_pkg::Q_CW-1:0]  r_count, n_count;
    logic                      pop_en;

    assign pop_en = i_pop && (r_count != '0);

    // Pointer and fill count update.
    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = pop_en ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + tsd_pkg::Q_CW'(i_push) - tsd_pkg::Q_CW'(pop_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_push_data;
        end
    end

    assign o_head_valid = r_count != '0;
    assign o_head       = r_slot[r_rptr];
    assign o_level      = r_count;

endmodule

FILE: hw/rtl/tsd_back.sv
// ----------------------------------------------------------------------------
// Targa stream decoder back
// Places runs in the image, flips rows and drives the output register.
// ----------------------------------------------------------------------------
module tsd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  tsd_pkg::t_cmd  i_head,
    input  tsd_pkg::t_geom i_geom,
    output logic           o_pop,
    tsd_run_if.source      o_run
);

    logic        r_busy, n_busy;
    logic [7:0]  r_rem, n_rem;
    logic [15:0] r_row, n_row;
    logic [15:0] r_col, n_col;
    logic        r_out_valid;
    logic        out_free;
    logic        take;
    logic        step_en;
    logic [7:0]  cur_n;
    logic [16:0] space;

    assign out_free = !r_out_valid || o_run.ready;
    assign take     = i_head_valid && !r_busy && out_free;
    assign o_pop    = take;

    // Position walk: at most one row boundary per cycle.
    always_comb begin
        n_busy  = r_busy;
        n_rem   = r_rem;
        n_row   = r_row;
        n_col   = r_col;
        cur_n   = take ? i_head.len : r_rem;
        step_en = (take && i_head.has) || r_busy;
        space   = {1'b0, i_geom.width} - {1'b0, r_col};
        if (step_en) begin
            if ({9'd0, cur_n} < space) begin
                n_col  = r_col + {8'd0, cur_n};
                n_rem  = '0;
                n_busy = 1'b0;
            end else begin
                n_rem  = cur_n - space[7:0];
                n_col  = '0;
                n_row  = r_row + 16'd1;
                n_busy = (cur_n != space[7:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rem       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_rem  <= n_rem;
            r_row  <= n_row;
            r_col  <= n_col;
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (o_run.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            o_run.status     <= i_head.status;
            o_run.has_pixels <= i_head.has;
            o_run.red        <= i_head.rgb[23:16];
            o_run.green      <= i_head.rgb[15:8];
            o_run.blue       <= i_head.rgb[7:0];
            o_run.run_length <= i_head.len;
            o_run.image_done <= i_head.done;
            if (i_head.has) begin
                o_run.row    <= i_geom.top_down ? r_row : i_geom.height - 16'd1 - r_row;
                o_run.column <= r_col;
            end else begin
                o_run.row    <= '0;
                o_run.column <= '0;
            end
        end
    end

    assign o_run.valid = r_out_valid;

`ifndef SYNTHESIS
    a_busy_has_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem != 8'd0)
        else $error("run walk busy with nothing left");

    a_busy_from_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> $past(take))
        else $error("run walk started without a new item");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_run.has_pixels) |-> o_run.run_length != 8'd0)
        else $error("empty pixel run presented");

    a_no_pixels_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_run.has_pixels) |-> (o_run.row == 16'd0 && o_run.column == 16'd0))
        else $error("position shown on an item without pixels");
`endif

endmodule

FILE: hw/rtl/tga_stream_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// Targa stream pixel decoder
// Decodes a Targa file byte stream into coloured pixel runs.
// ----------------------------------------------------------------------------
// Usage: file bytes enter on i_byte (valid/ready), one byte per item, with
// last_byte set on the final byte. Results leave on o_run: a pixel run with
// its colour, length and first position, an error or truncation status, and
// image_done once the last image row is complete. Bytes that produce no
// result (header, ID field, colour map, packet headers, partial pixels) are
// taken silently.
// Throughput: one byte per cycle while the queue has room. A repeat run that
// crosses row boundaries keeps the placement unit busy, one boundary a cycle;
// the four-entry queue absorbs this, and input stalls only when the queue and the item in flight fill it.
// A result passes the colour table read stage, the queue and the output
// register before it is presented.
// Reset clears all parsing state; the colour table needs no clearing. After
// an error, the image end or the last byte, further bytes are ignored until
// reset. When the receiver stalls, the output holds and the queue fills
// before input is held off.
// ----------------------------------------------------------------------------
module tga_stream_pixel_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsd_byte_if.sink   i_byte,
    tsd_run_if.source  o_run
);

    logic                     push;
    tsd_pkg::t_cmd            push_data;
    tsd_pkg::t_geom           geom;
    logic                     pop;
    logic                     head_valid;
    tsd_pkg::t_cmd            head;
    logic [tsd_pkg::Q_CW-1:0] level;

    tsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .i_queue_level(level),
        .o_push       (push),
        .o_push_data  (push_data),
        .o_geom       (geom)
    );

    tsd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head_valid(head_valid),
        .o_head      (head),
        .o_level     (level)
    );

    tsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_valid(head_valid),
        .i_head      (head),
        .i_geom      (geom),
        .o_pop       (pop),
        .o_run       (o_run)
    );

endmodule
